// ===== rtl/tgr_pkg.sv =====
// Shared types, constants and the 5x7 font for the text glyph rasterizer.
`default_nettype none

package tgr_pkg;

    localparam int COORD_BITS_DEF = 16;

    localparam int GLYPH_W      = 5;
    localparam int GLYPH_H      = 7;
    localparam int GLYPH_PIXELS = GLYPH_W * GLYPH_H;
    localparam int FONT_ADVANCE = 6;
    localparam int LINE_HEIGHT  = 8;

    localparam int ORIGIN_W = 16;
    localparam int COLOR_W  = 32;
    localparam int PIX_W    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORE_COLOR     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT_BG = 3'd4;

    localparam logic [COLOR_W-1:0] FORE_COLOR_RESET = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0] BACK_COLOR_RESET = 32'h0000_0000;

    typedef logic [GLYPH_W-1:0] glyph_row_t;

    typedef struct packed {
        logic [GLYPH_PIXELS-1:0] emit;
        logic [GLYPH_PIXELS-1:0] lit;
        logic [PIX_W-1:0]        x;
        logic [PIX_W-1:0]        y;
    } glyph_load_t;

    localparam glyph_row_t DIGIT_FONT [0:9][0:6] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
    };

    localparam glyph_row_t ALPHA_FONT [0:25][0:6] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
    };

    localparam glyph_row_t UNKNOWN_FONT [0:6] =
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};

    function automatic glyph_row_t font_row(input logic [7:0] code, input logic [2:0] row);
        logic [7:0] up;
        logic [4:0] alpha_idx;
        logic [3:0] digit_idx;
        glyph_row_t bits;
        up = (code >= 8'h61 && code <= 8'h7A) ? code - 8'h20 : code;
        alpha_idx = 5'(up - 8'h41);
        digit_idx = 4'(up - 8'h30);
        bits = UNKNOWN_FONT[row];
        if (up >= 8'h41 && up <= 8'h5A)
        begin
            bits = ALPHA_FONT[alpha_idx][row];
        end
        else if (up >= 8'h30 && up <= 8'h39)
        begin
            bits = DIGIT_FONT[digit_idx][row];
        end
        else
        begin
            case (up)
                8'h20: bits = 5'h00;
                8'h2E: bits = (row == 3'd6) ? 5'h04 : 5'h00;
                8'h3A: bits = (row == 3'd2 || row == 3'd5) ? 5'h04 : 5'h00;
                8'h2D: bits = (row == 3'd3) ? 5'h1F : 5'h00;
                8'h5F: bits = (row == 3'd6) ? 5'h1F : 5'h00;
                8'h2F: bits = (row >= 3'd1 && row <= 3'd5) ?
                              (5'h01 << (row - 3'd1)) : 5'h00;
                default: bits = UNKNOWN_FONT[row];
            endcase
        end
        return bits;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tgr_cursor.sv =====
// Cursor state, byte decode and per-glyph pixel mask build.
`default_nettype none

module tgr_cursor #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic [7:0]                            char_code,
    input  wire logic                                  first_of_text,
    input  wire logic signed [tgr_pkg::ORIGIN_W-1:0]   origin_x,
    input  wire logic signed [tgr_pkg::ORIGIN_W-1:0]   origin_y,
    input  wire logic                                  transparent_bg,
    output logic                                       load_valid,
    output tgr_pkg::glyph_load_t                       load_data
);

    localparam int EXT_W = ((COORD_BITS > tgr_pkg::ORIGIN_W) ?
                            COORD_BITS : tgr_pkg::ORIGIN_W) + 1;

    typedef logic signed [EXT_W-1:0] ext_t;

    localparam ext_t CMAX = ext_t'((64'd1 << (COORD_BITS - 1)) - 64'd1);
    localparam ext_t CMIN = -CMAX - ext_t'(1);

    function automatic logic signed [COORD_BITS-1:0] sat_coord(input ext_t v);
        logic signed [COORD_BITS-1:0] r;
        if (v > CMAX)
        begin
            r = CMAX[COORD_BITS-1:0];
        end
        else if (v < CMIN)
        begin
            r = CMIN[COORD_BITS-1:0];
        end
        else
        begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_BITS-1:0] col_reg, col_next;
    logic signed [COORD_BITS-1:0] row_reg, row_next;
    logic signed [COORD_BITS-1:0] org_col, org_row;
    logic signed [COORD_BITS-1:0] base_col, base_row;
    ext_t                         col_ext, row_ext;
    ext_t                         px, py;
    logic [tgr_pkg::GLYPH_W-1:0]  x_ok;
    logic [tgr_pkg::GLYPH_H-1:0]  y_ok;
    tgr_pkg::glyph_row_t          row_bits;
    logic                         printable;
    logic                         on;

    assign org_col  = sat_coord(ext_t'(origin_x));
    assign org_row  = sat_coord(ext_t'(origin_y));
    assign base_col = first_of_text ? org_col : col_reg;
    assign base_row = first_of_text ? org_row : row_reg;
    assign col_ext  = ext_t'(base_col);
    assign row_ext  = ext_t'(base_row);
    assign printable = (char_code != tgr_pkg::CHAR_NUL) &&
                       (char_code != tgr_pkg::CHAR_NEWLINE);

    always_comb
    begin
        px = '0;
        py = '0;
        for (int c = 0; c < tgr_pkg::GLYPH_W; c++)
        begin
            px      = col_ext + ext_t'(c);
            x_ok[c] = !px[EXT_W-1] && (px <= CMAX);
        end
        for (int r = 0; r < tgr_pkg::GLYPH_H; r++)
        begin
            py      = row_ext + ext_t'(r);
            y_ok[r] = !py[EXT_W-1] && (py <= CMAX);
        end
    end

    always_comb
    begin
        load_data   = '0;
        row_bits    = '0;
        on          = 1'b0;
        load_data.x = col_ext[tgr_pkg::PIX_W-1:0];
        load_data.y = row_ext[tgr_pkg::PIX_W-1:0];
        for (int r = 0; r < tgr_pkg::GLYPH_H; r++)
        begin
            row_bits = tgr_pkg::font_row(char_code, 3'(r));
            for (int c = 0; c < tgr_pkg::GLYPH_W; c++)
            begin
                on = row_bits[tgr_pkg::GLYPH_W-1-c];
                load_data.lit[r*tgr_pkg::GLYPH_W + c]  = on;
                load_data.emit[r*tgr_pkg::GLYPH_W + c] =
                    (on || !transparent_bg) && x_ok[c] && y_ok[r];
            end
        end
    end

    assign load_valid = accept && printable && (|load_data.emit);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (char_code == tgr_pkg::CHAR_NUL)
            begin
                col_next = base_col;
                row_next = base_row;
            end
            else if (char_code == tgr_pkg::CHAR_NEWLINE)
            begin
                col_next = org_col;
                row_next = sat_coord(row_ext + ext_t'(tgr_pkg::LINE_HEIGHT));
            end
            else
            begin
                col_next = sat_coord(col_ext + ext_t'(tgr_pkg::FONT_ADVANCE));
                row_next = base_row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tgr_pixel_seq.sv =====
// Pixel sequencer: walks the glyph mask into the output register one pixel a cycle while not stalled.
`default_nettype none

module tgr_pixel_seq (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load_valid,
    input  wire tgr_pkg::glyph_load_t               load_data,
    input  wire logic [tgr_pkg::COLOR_W-1:0]        fore_color,
    input  wire logic [tgr_pkg::COLOR_W-1:0]        back_color,
    input  wire logic                               out_stall,
    output logic                                    out_valid,
    output logic [tgr_pkg::PIX_W-1:0]               pixel_x,
    output logic [tgr_pkg::PIX_W-1:0]               pixel_y,
    output logic [tgr_pkg::COLOR_W-1:0]             pixel_color,
    output logic                                    last_pixel,
    output logic                                    seq_free,
    output logic                                    seq_busy
);

    localparam int N = tgr_pkg::GLYPH_PIXELS;

    logic [N-1:0]                   emit_reg, emit_next;
    logic [N-1:0]                   lit_reg;
    logic [tgr_pkg::PIX_W-1:0]      xb_reg, yb_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [tgr_pkg::PIX_W-1:0]      x_reg, y_reg;
    logic [tgr_pkg::COLOR_W-1:0]    color_reg;
    logic                           last_reg;

    logic [N-1:0]                   pick;
    logic [N-1:0]                   remaining;
    logic [tgr_pkg::GLYPH_W-1:0]    col_hot;
    logic [tgr_pkg::GLYPH_H-1:0]    row_hot;
    logic [2:0]                     col_idx, row_idx;
    logic                           issue;
    logic                           pick_lit;

    assign seq_busy  = |emit_reg;
    assign issue     = seq_busy && (!out_valid_reg || !out_stall);
    assign pick      = emit_reg & (~emit_reg + N'(1));
    assign remaining = emit_reg & ~pick;
    assign pick_lit  = |(pick & lit_reg);
    assign seq_free  = !seq_busy || (issue && (remaining == '0));

    always_comb
    begin
        col_hot = '0;
        row_hot = '0;
        col_idx = '0;
        row_idx = '0;
        for (int r = 0; r < tgr_pkg::GLYPH_H; r++)
        begin
            row_hot[r] = |pick[r*tgr_pkg::GLYPH_W +: tgr_pkg::GLYPH_W];
            for (int c = 0; c < tgr_pkg::GLYPH_W; c++)
            begin
                col_hot[c] = col_hot[c] | pick[r*tgr_pkg::GLYPH_W + c];
            end
        end
        for (int c = 0; c < tgr_pkg::GLYPH_W; c++)
        begin
            if (col_hot[c])
            begin
                col_idx = col_idx | 3'(c);
            end
        end
        for (int r = 0; r < tgr_pkg::GLYPH_H; r++)
        begin
            if (row_hot[r])
            begin
                row_idx = row_idx | 3'(r);
            end
        end
    end

    always_comb
    begin
        emit_next = emit_reg;
        if (load_valid)
        begin
            emit_next = load_data.emit;
        end
        else if (issue)
        begin
            emit_next = remaining;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (issue)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid)
        begin
            lit_reg <= load_data.lit;
            xb_reg  <= load_data.x;
            yb_reg  <= load_data.y;
        end
        if (issue)
        begin
            x_reg     <= xb_reg + tgr_pkg::PIX_W'(col_idx);
            y_reg     <= yb_reg + tgr_pkg::PIX_W'(row_idx);
            color_reg <= pick_lit ? fore_color : back_color;
            last_reg  <= (remaining == '0);
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = x_reg;
    assign pixel_y     = y_reg;
    assign pixel_color = color_reg;
    assign last_pixel  = last_reg;

endmodule

`default_nettype wire

// ===== rtl/text_glyph_rasterizer.sv =====
// Text glyph rasterizer top level: configuration registers, cursor and pixel sequencer.
//
//   channel | direction | handshake               | beat
//   --------+-----------+-------------------------+------------------------------------
//   input   | in        | in_valid / in_stall     | char_code, first_of_text
//   output  | out       | out_valid / out_stall   | pixel_x, pixel_y, pixel_color, last_pixel
//   config  | in        | cfg_we                  | cfg_index, cfg_data
//
// A printable byte writes one pixel beat per emitted pixel, up to 35; newline, zero and
// fully clipped bytes write none. The pixel sequencer issues one pixel a cycle unless
// out_stall holds it, and takes the next byte in the cycle its final pixel issues.
// Reset is asynchronous and clears the cursor, the pixel mask and the output valid.
// out_stall holds the output register and the sequencer; in_stall is high while pixels
// of the current glyph remain to be issued.
`default_nettype none

module text_glyph_rasterizer #(
    parameter int COORD_BITS = tgr_pkg::COORD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           char_code,
    input  wire logic                                 first_of_text,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [tgr_pkg::PIX_W-1:0]                 pixel_x,
    output logic [tgr_pkg::PIX_W-1:0]                 pixel_y,
    output logic [tgr_pkg::COLOR_W-1:0]               pixel_color,
    output logic                                      last_pixel,
    input  wire logic                                 cfg_we,
    input  wire logic [tgr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [tgr_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic signed [tgr_pkg::ORIGIN_W-1:0] origin_x_reg;
    logic signed [tgr_pkg::ORIGIN_W-1:0] origin_y_reg;
    logic [tgr_pkg::COLOR_W-1:0]         fore_color_reg;
    logic [tgr_pkg::COLOR_W-1:0]         back_color_reg;
    logic                                transparent_bg_reg;

    logic                  accept;
    logic                  load_valid;
    tgr_pkg::glyph_load_t  load_data;
    logic                  seq_free;
    logic                  seq_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            fore_color_reg     <= tgr_pkg::FORE_COLOR_RESET;
            back_color_reg     <= tgr_pkg::BACK_COLOR_RESET;
            transparent_bg_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tgr_pkg::REG_ORIGIN_X:
                    origin_x_reg <= cfg_data[tgr_pkg::ORIGIN_W-1:0];
                tgr_pkg::REG_ORIGIN_Y:
                    origin_y_reg <= cfg_data[tgr_pkg::ORIGIN_W-1:0];
                tgr_pkg::REG_FORE_COLOR:
                    fore_color_reg <= cfg_data[tgr_pkg::COLOR_W-1:0];
                tgr_pkg::REG_BACK_COLOR:
                    back_color_reg <= cfg_data[tgr_pkg::COLOR_W-1:0];
                tgr_pkg::REG_TRANSPARENT_BG:
                    transparent_bg_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    assign in_stall = !seq_free;
    assign accept   = in_valid && seq_free;

    tgr_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .char_code      (char_code),
        .first_of_text  (first_of_text),
        .origin_x       (origin_x_reg),
        .origin_y       (origin_y_reg),
        .transparent_bg (transparent_bg_reg),
        .load_valid     (load_valid),
        .load_data      (load_data)
    );

    tgr_pixel_seq u_pixel_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load_data   (load_data),
        .fore_color  (fore_color_reg),
        .back_color  (back_color_reg),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel),
        .seq_free    (seq_free),
        .seq_busy    (seq_busy)
    );

    a_nonfinal_has_more: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_pixel) |-> seq_busy)
        else $error("non-final pixel beat with no pixels pending");

    a_pending_progress: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy |=> (seq_busy || out_valid))
        else $error("pending pixels vanished without an output beat");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load_valid |-> (in_valid && !in_stall))
        else $error("glyph loaded without an accepted input beat");

endmodule

`default_nettype wire

// ===== tb/text_glyph_rasterizer_tb.sv =====
// Self-checking testbench for the text glyph rasterizer: glyph pixel predictor and scoreboard.
`default_nettype none

package tgr_check_pkg;

    localparam int COORD_MAX = 32767;
    localparam int COORD_MIN = -32768;
    localparam int CELL_W    = 5;
    localparam int CELL_H    = 7;
    localparam int ADVANCE   = 6;
    localparam int LINE_STEP = 8;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    localparam logic [7:0] MARKS [7] = '{CH_SPACE, CH_DASH, CH_DOT, CH_SLASH,
                                         CH_COLON, CH_QMARK, CH_UNDER};

    localparam bit [4:0] DIGIT_ROWS [10][7] = '{
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C}
    };

    localparam bit [4:0] ALPHA_ROWS [26][7] = '{
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F}
    };

    localparam bit [4:0] QMARK_ROWS [7] = '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};

    typedef struct {
        logic [tgr_pkg::PIX_W-1:0]   x;
        logic [tgr_pkg::PIX_W-1:0]   y;
        logic [tgr_pkg::COLOR_W-1:0] color;
        logic                        last;
    } pixel_t;

    function automatic bit [4:0] glyph_row(input logic [7:0] code, input int r);
        logic [7:0] up;
        up = code;
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z)
        begin
            up = code - CASE_GAP;
        end
        if (up >= CH_UPPER_A && up <= CH_UPPER_Z)
        begin
            return ALPHA_ROWS[up - CH_UPPER_A][r];
        end
        if (up >= CH_ZERO && up <= CH_NINE)
        begin
            return DIGIT_ROWS[up - CH_ZERO][r];
        end
        case (up)
            CH_SPACE: return 5'h00;
            CH_DOT:   return (r == 6) ? 5'h04 : 5'h00;
            CH_COLON: return (r == 2 || r == 5) ? 5'h04 : 5'h00;
            CH_DASH:  return (r == 3) ? 5'h1F : 5'h00;
            CH_UNDER: return (r == 6) ? 5'h1F : 5'h00;
            CH_SLASH: return (r >= 1 && r <= 5) ? 5'(1 << (r - 1)) : 5'h00;
            default:  return QMARK_ROWS[r];
        endcase
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > COORD_MAX)
        begin
            return COORD_MAX;
        end
        if (v < COORD_MIN)
        begin
            return COORD_MIN;
        end
        return v;
    endfunction

    class glyph_scoreboard;
        int                          org_x;
        int                          org_y;
        logic [tgr_pkg::COLOR_W-1:0] fg;
        logic [tgr_pkg::COLOR_W-1:0] bg;
        bit                          clear_bg;
        int                          cur_col;
        int                          cur_row;
        pixel_t                      due_pixels[$];
        int                          errors;

        function new();
            org_x    = 0;
            org_y    = 0;
            fg       = tgr_pkg::FORE_COLOR_RESET;
            bg       = tgr_pkg::BACK_COLOR_RESET;
            clear_bg = 1'b0;
            cur_col  = 0;
            cur_row  = 0;
            errors   = 0;
        endfunction

        function void set_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
                              input logic [tgr_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                tgr_pkg::REG_ORIGIN_X:       org_x = int'($signed(data[15:0]));
                tgr_pkg::REG_ORIGIN_Y:       org_y = int'($signed(data[15:0]));
                tgr_pkg::REG_FORE_COLOR:     fg = data;
                tgr_pkg::REG_BACK_COLOR:     bg = data;
                tgr_pkg::REG_TRANSPARENT_BG: clear_bg = data[0];
                default: ;
            endcase
        endfunction

        function void note_byte(input logic [7:0] code, input logic first);
            bit [4:0] bits;
            bit       on;
            bit       have;
            int       px;
            int       py;
            pixel_t   held;
            have = 1'b0;
            if (first)
            begin
                cur_col = clamp_coord(org_x);
                cur_row = clamp_coord(org_y);
            end
            if (code == tgr_pkg::CHAR_NUL)
            begin
                return;
            end
            if (code == tgr_pkg::CHAR_NEWLINE)
            begin
                cur_col = clamp_coord(org_x);
                cur_row = clamp_coord(cur_row + LINE_STEP);
                return;
            end
            for (int r = 0; r < CELL_H; r++)
            begin
                bits = glyph_row(code, r);
                for (int c = 0; c < CELL_W; c++)
                begin
                    on = bits[CELL_W - 1 - c];
                    px = cur_col + c;
                    py = cur_row + r;
                    if (!on && clear_bg)
                    begin
                        continue;
                    end
                    if (px < 0 || py < 0 || px > COORD_MAX || py > COORD_MAX)
                    begin
                        continue;
                    end
                    if (have)
                    begin
                        due_pixels.push_back(held);
                    end
                    held.x     = px[tgr_pkg::PIX_W-1:0];
                    held.y     = py[tgr_pkg::PIX_W-1:0];
                    held.color = on ? fg : bg;
                    held.last  = 1'b0;
                    have       = 1'b1;
                end
            end
            if (have)
            begin
                held.last = 1'b1;
                due_pixels.push_back(held);
            end
            cur_col = clamp_coord(cur_col + ADVANCE);
        endfunction

        function void check_pixel(input logic [tgr_pkg::PIX_W-1:0] x,
                                  input logic [tgr_pkg::PIX_W-1:0] y,
                                  input logic [tgr_pkg::COLOR_W-1:0] color,
                                  input logic last);
            pixel_t want;
            if (due_pixels.size() == 0)
            begin
                $error("unexpected pixel beat x=%0d y=%0d color=%h", x, y, color);
                errors++;
                return;
            end
            want = due_pixels.pop_front();
            if (x !== want.x)
            begin
                $error("pixel_x expected %0d actual %0d", want.x, x);
                errors++;
            end
            if (y !== want.y)
            begin
                $error("pixel_y expected %0d actual %0d", want.y, y);
                errors++;
            end
            if (color !== want.color)
            begin
                $error("pixel_color expected %h actual %h", want.color, color);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last_pixel expected %0b actual %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_pixels.size();
        endfunction
    endclass

endpackage

module text_glyph_rasterizer_tb;

    localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;
    localparam logic [tgr_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 3'd7;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES     = 60;
    localparam int TIMEOUT          = 12_000_000;
    localparam int DIRECTED_COUNT   = 19;

    localparam logic [7:0] DIRECTED_CODES [DIRECTED_COUNT] = '{
        8'h41, tgr_check_pkg::CH_LOWER_Z, tgr_check_pkg::CH_ZERO,
        tgr_check_pkg::CH_NINE, tgr_check_pkg::CH_SPACE, tgr_check_pkg::CH_DOT,
        tgr_check_pkg::CH_COLON, tgr_check_pkg::CH_DASH, tgr_check_pkg::CH_UNDER,
        tgr_check_pkg::CH_SLASH, tgr_check_pkg::CH_QMARK, 8'h80, 8'hFF,
        tgr_pkg::CHAR_NUL, tgr_pkg::CHAR_NEWLINE, 8'h6D, tgr_pkg::CHAR_NUL,
        tgr_check_pkg::CH_DEL, 8'h51
    };
    localparam bit DIRECTED_FIRST [DIRECTED_COUNT] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0
    };

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] char_code;
    logic first_of_text;
    logic out_valid;
    logic out_stall;
    logic [tgr_pkg::PIX_W-1:0] pixel_x;
    logic [tgr_pkg::PIX_W-1:0] pixel_y;
    logic [tgr_pkg::COLOR_W-1:0] pixel_color;
    logic last_pixel;
    logic cfg_we;
    logic [tgr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tgr_pkg::CFG_DATA_W-1:0] cfg_data;

    bit calm = 1'b0;
    bit long_hold = 1'b0;
    tgr_check_pkg::glyph_scoreboard sb;

    text_glyph_rasterizer i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .first_of_text (first_of_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .pixel_color   (pixel_color),
        .last_pixel    (last_pixel),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_pixel(pixel_x, pixel_y, pixel_color, last_pixel);
        end
    end

    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #(TIMEOUT);
        $display("Mismatches found");
        $finish;
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return tgr_pkg::CHAR_NEWLINE;
        end
        if (r < 9)
        begin
            return tgr_pkg::CHAR_NUL;
        end
        if (r < 20)
        begin
            return 8'($urandom_range(0, 255));
        end
        if (r < 32)
        begin
            return tgr_check_pkg::MARKS[$urandom_range(0, 6)];
        end
        return 8'($urandom_range(tgr_check_pkg::CH_SPACE, tgr_check_pkg::CH_TILDE));
    endfunction

    function automatic logic [tgr_pkg::CFG_DATA_W-1:0] origin_word(input int v);
        logic [15:0] junk;
        junk = 16'($urandom);
        return {junk, v[15:0]};
    endfunction

    task automatic send_byte(input logic [7:0] code, input logic first);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        char_code     <= code;
        first_of_text <= first;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(code, first);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tgr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tgr_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic set_view(input int ox, input int oy,
                            input logic [tgr_pkg::COLOR_W-1:0] fg,
                            input logic [tgr_pkg::COLOR_W-1:0] bg,
                            input logic clear);
        write_reg(3'($urandom_range(REG_UNUSED_FIRST, REG_UNUSED_LAST)), $urandom);
        write_reg(tgr_pkg::REG_ORIGIN_X, origin_word(ox));
        write_reg(tgr_pkg::REG_ORIGIN_Y, origin_word(oy));
        write_reg(tgr_pkg::REG_FORE_COLOR, fg);
        write_reg(tgr_pkg::REG_BACK_COLOR, bg);
        write_reg(tgr_pkg::REG_TRANSPARENT_BG, {31'($urandom), clear});
        cfg_we <= 1'b0;
    endtask

    task automatic run_text(input int count);
        for (int k = 0; k < count; k++)
        begin
            send_byte(pick_char(), $urandom_range(0, 9) == 0);
        end
        settle();
    endtask

    initial
    begin
        sb            = new();
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        char_code     = '0;
        first_of_text = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int k = 0; k < DIRECTED_COUNT; k++)
        begin
            send_byte(DIRECTED_CODES[k], DIRECTED_FIRST[k]);
        end
        settle();

        set_view(5, 3, $urandom, $urandom, 1'b0);
        send_byte(pick_char(), 1'b1);
        run_text(29);

        set_view(-3, -4, '0, '1, 1'b0);
        send_byte(tgr_check_pkg::CH_UPPER_A, 1'b1);
        long_hold = 1'b1;
        run_text(24);

        set_view(32760, 32762, $urandom, $urandom, 1'b1);
        send_byte(8'h4D, 1'b1);
        run_text(19);

        set_view(tgr_check_pkg::COORD_MIN, tgr_check_pkg::COORD_MIN, '1, '0, 1'b0);
        send_byte(tgr_check_pkg::CH_QMARK, 1'b1);
        run_text(14);

        set_view($urandom_range(0, 300), $urandom_range(0, 300), $urandom, $urandom, 1'b1);
        send_byte(pick_char(), 1'b1);
        run_text(34);

        set_view(tgr_check_pkg::COORD_MAX, tgr_check_pkg::COORD_MAX, $urandom, $urandom,
                 1'b0);
        send_byte(tgr_check_pkg::CH_UPPER_Z, 1'b1);
        run_text(14);

        set_view(100, 32700, $urandom, $urandom, 1'($urandom_range(0, 1)));
        send_byte(pick_char(), 1'b1);
        run_text(29);

        calm = 1'b1;
        set_view($urandom_range(0, 1000), $urandom_range(0, 1000), $urandom, $urandom, 1'b0);
        send_byte(pick_char(), 1'b1);
        run_text(40);

        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
